### rtl/nll_pkg.sv
// Shared types, widths and constants for the ladder lowpass.
// Holds the controller command struct, coefficient struct and the tanh table function.
package nll_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int STAGE_WIDTH  = SAMPLE_WIDTH + 4;
	localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
	localparam int OVERSAMPLE   = 2;
	// table depth is a power of two
	localparam int TANH_DEPTH   = 256;
	localparam int LOG2_DEPTH   = $clog2(TANH_DEPTH);
	localparam int TAB_AW       = $clog2(TANH_DEPTH + 1);
	localparam int TANH_VAL_W   = 31;

	localparam int NUM_STAGES   = 5;
	localparam int LAST_STAGE   = NUM_STAGES - 1;
	localparam int STAGE_IDX_W  = $clog2(NUM_STAGES);
	localparam int PASS_W       = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

	// configuration port
	localparam int CFG_INDEX_W  = 8;
	localparam int CFG_DATA_W   = 32;
	localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF    = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_RESONANCE = CFG_INDEX_W'(1);

	localparam int CUTOFF_W     = 18;
	localparam int RES_W        = 17;
	localparam int H0_W         = 18;
	localparam int H1_W         = 16;
	localparam int COEF_C_W     = 19;
	localparam int CUTOFF_RESET = 6554;
	localparam int RES_RESET    = 0;
	localparam int H0_RESET     = (CUTOFF_RESET * 10 + 6) / 13;
	localparam int H1_RESET     = (CUTOFF_RESET * 3 + 6) / 13;
	localparam int C_RESET      = 65536 - CUTOFF_RESET;

	// divide by 13 as multiply by reciprocal, exact for the coefficient range
	localparam int DIVN_W       = CUTOFF_W + 4;
	localparam int RECIP_SH     = 25;
	localparam int RECIP_W      = 22;
	localparam int RECIP_M      = ((1 << RECIP_SH) + 12) / 13;
	localparam int DIVP_W       = DIVN_W + RECIP_W;

	// shared multiplier
	localparam int MUL_A_W      = (STAGE_WIDTH + 3 > TANH_VAL_W + 1) ?
		STAGE_WIDTH + 3 : TANH_VAL_W + 1;
	localparam int MUL_B_W      = COEF_C_W;
	localparam int PROD_W       = MUL_A_W + MUL_B_W;
	localparam int ACC_W        = PROD_W + 2;
	localparam int U_W          = PROD_W - 15;
	localparam int RND16        = 1 << 15;
	localparam int RND_SH       = 31 - FRAC_BITS;
	localparam int RND_ADD      = (RND_SH > 0) ? (1 << (RND_SH - 1)) : 0;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_FB,
		MUL_INTERP,
		MUL_H1,
		MUL_C,
		MUL_H0
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_FB,
		ACC_TANH,
		ACC_LOAD,
		ACC_ADD,
		ACC_STAGE
	} acc_op_t;

	typedef enum logic [1:0] {
		TAB_NONE,
		TAB_LO,
		TAB_HI
	} tab_rd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FB,
		S_FB_ACC,
		S_TAB_LO,
		S_TAB_HI,
		S_INTERP,
		S_LADDER,
		S_LAST
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_H1,
		PH_C,
		PH_H0
	} phase_t;

	typedef struct packed {
		logic                   load_x;
		logic                   x_en;
		mul_op_t                mul_op;
		logic [STAGE_IDX_W-1:0] mul_stage;
		acc_op_t                acc_op;
		tab_rd_t                tab_rd;
		logic                   commit;
		logic                   capture;
	} nll_cmd_t;

	typedef struct packed {
		logic [RES_W-1:0]           r;
		logic [H0_W-1:0]            h0;
		logic [H1_W-1:0]            h1;
		logic signed [COEF_C_W-1:0] c;
	} nll_coef_t;

	localparam longint Q31_ONE = longint'(1) <<< 31;

	function automatic longint q31_mul(input longint a, input longint b);
		return (a * b + (longint'(1) <<< 30)) >>> 31;
	endfunction

	// unsigned long division by shift and subtract, used while building the table
	function automatic longint udiv64(input longint num, input longint den);
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		logic [64:0] rem;
		n   = num;
		d   = den;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return longint'(q);
	endfunction

	// tanh(4k/depth): odd series at a sixteenth of the argument, then four doublings
	function automatic logic [TANH_VAL_W-1:0] tanh_entry(input int k);
		longint z;
		longint z2;
		longint p;
		longint t;
		longint den;
		z = ((longint'(k) <<< 31) + 2 * TANH_DEPTH) / (4 * TANH_DEPTH);
		z2 = q31_mul(z, z);
		p = q31_mul(z, z2);
		t = z - p / 3;
		p = q31_mul(p, z2);
		t = t + 2 * p / 15;
		p = q31_mul(p, z2);
		t = t - 17 * p / 315;
		p = q31_mul(p, z2);
		t = t + 62 * p / 2835;
		for (int i = 0; i < 4; i++) begin
			den = Q31_ONE + q31_mul(t, t);
			t = udiv64((t <<< 32) + (den >>> 1), den);
			if (t > Q31_ONE - 1) begin
				t = Q31_ONE - 1;
			end
		end
		return TANH_VAL_W'(t);
	endfunction

endpackage

### rtl/nll_cfg.sv
// Configuration registers for the ladder lowpass and the derived filter coefficients.
// Depends on nll_pkg for widths, register indexes and reset values.
module nll_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nll_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [nll_pkg::CFG_DATA_W-1:0]  cfg_data,
	output nll_pkg::nll_coef_t              coef
);
	import nll_pkg::*;

	logic [CUTOFF_W-1:0] wr_g;
	logic [DIVN_W-1:0]   n0;
	logic [DIVN_W-1:0]   n1;
	logic [DIVP_W-1:0]   p0;
	logic [DIVP_W-1:0]   p1;

	logic [RES_W-1:0]           r_q;
	logic [H0_W-1:0]            h0_q;
	logic [H1_W-1:0]            h1_q;
	logic signed [COEF_C_W-1:0] c_q;

	assign cfg_ready = 1'b1;
	assign wr_g = cfg_data[CUTOFF_W-1:0];

	// h0 = round(10g/13), h1 = round(3g/13)
	assign n0 = (DIVN_W'(wr_g) << 3) + (DIVN_W'(wr_g) << 1) + DIVN_W'(6);
	assign n1 = (DIVN_W'(wr_g) << 1) + DIVN_W'(wr_g) + DIVN_W'(6);
	assign p0 = DIVP_W'(n0) * DIVP_W'(RECIP_M);
	assign p1 = DIVP_W'(n1) * DIVP_W'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q  <= RES_W'(RES_RESET);
			h0_q <= H0_W'(H0_RESET);
			h1_q <= H1_W'(H1_RESET);
			c_q  <= COEF_C_W'(C_RESET);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_CUTOFF) begin
				h0_q <= p0[RECIP_SH +: H0_W];
				h1_q <= p1[RECIP_SH +: H1_W];
				c_q  <= COEF_C_W'(65536) - signed'({1'b0, wr_g});
			end else if (cfg_index == CFG_RESONANCE) begin
				r_q <= cfg_data[RES_W-1:0];
			end
		end
	end

	assign coef.r  = r_q;
	assign coef.h0 = h0_q;
	assign coef.h1 = h1_q;
	assign coef.c  = c_q;

endmodule

### rtl/nll_ctrl.sv
// Sequencer for the ladder lowpass: steps the shared multiplier through each pass.
// Depends on nll_pkg for the state and command types.
module nll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output nll_pkg::nll_cmd_t cmd
);
	import nll_pkg::*;

	ctrl_state_t            state_q, state_d;
	phase_t                 ph_q, ph_d;
	logic [STAGE_IDX_W-1:0] stage_q, stage_d;
	logic [PASS_W-1:0]      pass_q, pass_d;
	logic                   out_valid_q, out_valid_d;
	logic                   first_pass;
	logic                   last_pass;
	logic                   stall;

	assign first_pass = (pass_q == '0);
	assign last_pass  = (pass_q == PASS_W'(OVERSAMPLE - 1));
	// a new result may not overwrite one still waiting
	assign stall      = first_pass && out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_H1;
			stage_q     <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ph_q        <= ph_d;
			stage_q     <= stage_d;
			pass_q      <= pass_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ph_d        = ph_q;
		stage_d     = stage_q;
		pass_d      = pass_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		in_ready    = 1'b0;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_x = 1'b1;
					pass_d     = '0;
					state_d    = S_FB;
				end
			end
			S_FB: begin
				cmd.x_en   = first_pass;
				cmd.mul_op = MUL_FB;
				state_d    = S_FB_ACC;
			end
			S_FB_ACC: begin
				cmd.x_en   = first_pass;
				cmd.acc_op = ACC_FB;
				state_d    = S_TAB_LO;
			end
			S_TAB_LO: begin
				cmd.tab_rd = TAB_LO;
				state_d    = S_TAB_HI;
			end
			S_TAB_HI: begin
				cmd.tab_rd = TAB_HI;
				state_d    = S_INTERP;
			end
			S_INTERP: begin
				cmd.mul_op = MUL_INTERP;
				stage_d    = STAGE_IDX_W'(1);
				ph_d       = PH_H1;
				state_d    = S_LADDER;
			end
			S_LADDER: begin
				cmd.mul_stage = stage_q;
				case (ph_q)
					PH_H1: begin
						// finish the previous stage while its successor starts
						cmd.mul_op = MUL_H1;
						cmd.acc_op = (stage_q == STAGE_IDX_W'(1)) ? ACC_TANH : ACC_STAGE;
						ph_d       = PH_C;
					end
					PH_C: begin
						cmd.mul_op = MUL_C;
						cmd.acc_op = ACC_LOAD;
						ph_d       = PH_H0;
					end
					PH_H0: begin
						cmd.mul_op = MUL_H0;
						cmd.acc_op = ACC_ADD;
						ph_d       = PH_H1;
						if (stage_q == STAGE_IDX_W'(LAST_STAGE)) begin
							state_d = S_LAST;
						end else begin
							stage_d = STAGE_IDX_W'(stage_q + 1'b1);
						end
					end
					default: begin
						ph_d = PH_H1;
					end
				endcase
			end
			S_LAST: begin
				if (!stall) begin
					cmd.acc_op  = ACC_STAGE;
					cmd.commit  = 1'b1;
					cmd.capture = first_pass;
					if (first_pass) begin
						out_valid_d = 1'b1;
					end
					if (last_pass) begin
						state_d = S_IDLE;
					end else begin
						pass_d  = PASS_W'(pass_q + 1'b1);
						state_d = S_FB;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/nll_datapath.sv
// Datapath of the ladder lowpass: shared multiplier, accumulator, tanh table and stages.
// Depends on nll_pkg; driven by commands from nll_ctrl and coefficients from nll_cfg.
module nll_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [nll_pkg::SAMPLE_WIDTH-1:0] sample_in,
	input  nll_pkg::nll_cmd_t                      cmd,
	input  nll_pkg::nll_coef_t                     coef,
	output logic signed [nll_pkg::SAMPLE_WIDTH-1:0] sample_out
);
	import nll_pkg::*;

	function automatic logic signed [STAGE_WIDTH-1:0] sat_stage(
		input logic signed [ACC_W-1:0] v);
		logic [ACC_W-STAGE_WIDTH:0] top;
		top = v[ACC_W-1:STAGE_WIDTH-1];
		if (&top || ~|top) begin
			return v[STAGE_WIDTH-1:0];
		end
		return v[ACC_W-1] ? {1'b1, {(STAGE_WIDTH-1){1'b0}}} :
			{1'b0, {(STAGE_WIDTH-1){1'b1}}};
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
		input logic signed [STAGE_WIDTH-1:0] v);
		logic [STAGE_WIDTH-SAMPLE_WIDTH:0] top;
		top = v[STAGE_WIDTH-1:SAMPLE_WIDTH-1];
		if (&top || ~|top) begin
			return v[SAMPLE_WIDTH-1:0];
		end
		return v[STAGE_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} :
			{1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	endfunction

	// tanh table, Q31 for |u| in [0, 4]
	logic [TANH_VAL_W-1:0] tanh_rom [TANH_DEPTH+1];

	for (genvar k = 0; k <= TANH_DEPTH; k++) begin : g_rom
		localparam logic [TANH_VAL_W-1:0] ENTRY = tanh_entry(k);
		assign tanh_rom[k] = ENTRY;
	end

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [STAGE_WIDTH-1:0]  y_q   [NUM_STAGES];
	logic signed [STAGE_WIDTH-1:0]  nxt_q [NUM_STAGES];
	logic signed [PROD_W-1:0]       prod_q;
	logic [STAGE_IDX_W-1:0]         stage_s1;
	logic signed [ACC_W-1:0]        acc_q;
	logic [TAB_AW-1:0]              idx_q;
	logic [15:0]                    f_q;
	logic                           neg_q;
	logic [TANH_VAL_W-1:0]          lo_q;
	logic [TANH_VAL_W-1:0]          hi_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;

	logic signed [SAMPLE_WIDTH-1:0] x_fb;
	logic signed [MUL_A_W-1:0]      dfb;
	logic signed [MUL_A_W-1:0]      diff;
	logic signed [MUL_A_W-1:0]      mul_a;
	logic signed [MUL_B_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]       prod;
	logic [STAGE_IDX_W-1:0]         stage_m1;

	logic signed [PROD_W-1:0]       fb_sh;
	logic signed [U_W-1:0]          u;
	logic [U_W-1:0]                 u_abs;
	logic [U_W+LOG2_DEPTH-1:0]      pos;
	logic                           u_big;

	logic [TAB_AW-1:0]              idx_hi;
	logic [TAB_AW-1:0]              rd_addr;
	logic [TANH_VAL_W-1:0]          rom_rd;

	logic signed [U_W-1:0]          t_sum;
	logic signed [U_W-1:0]          t_rnd;
	logic signed [U_W-1:0]          t_val;
	logic signed [STAGE_WIDTH-1:0]  tanh_res;

	logic signed [ACC_W-1:0]        st_sum;
	logic signed [ACC_W-1:0]        st_sh;
	logic signed [STAGE_WIDTH-1:0]  st_res;

	// feedback term 2*r*(2*y4 - x) = r*(4*y4 - 2*x)
	assign x_fb = cmd.x_en ? x_q : '0;
	assign dfb  = (MUL_A_W'(y_q[LAST_STAGE]) <<< 2) - (MUL_A_W'(x_fb) <<< 1);
	assign diff = MUL_A_W'(signed'({1'b0, hi_q})) - MUL_A_W'(signed'({1'b0, lo_q}));
	assign stage_m1 = STAGE_IDX_W'(cmd.mul_stage - 1'b1);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			MUL_FB: begin
				mul_a = dfb;
				mul_b = MUL_B_W'(signed'({1'b0, coef.r}));
			end
			MUL_INTERP: begin
				mul_a = diff;
				mul_b = MUL_B_W'(signed'({1'b0, f_q}));
			end
			MUL_H1: begin
				mul_a = MUL_A_W'(y_q[stage_m1]);
				mul_b = MUL_B_W'(signed'({1'b0, coef.h1}));
			end
			MUL_C: begin
				mul_a = MUL_A_W'(y_q[cmd.mul_stage]);
				mul_b = coef.c;
			end
			MUL_H0: begin
				mul_a = MUL_A_W'(nxt_q[stage_m1]);
				mul_b = MUL_B_W'(signed'({1'b0, coef.h0}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// u = x - round(2*r*d / 2^16), then table index and interpolation fraction
	assign fb_sh = (prod_q + PROD_W'(RND16)) >>> 16;
	assign u     = U_W'(x_fb) - U_W'(fb_sh);
	assign u_abs = u[U_W-1] ? U_W'(-u) : U_W'(u);
	assign u_big = |u_abs[U_W-1:FRAC_BITS+2];
	assign pos   = {u_abs, {LOG2_DEPTH{1'b0}}};

	assign idx_hi  = (idx_q == TAB_AW'(TANH_DEPTH)) ? idx_q : TAB_AW'(idx_q + 1'b1);
	assign rd_addr = (cmd.tab_rd == TAB_HI) ? idx_hi : idx_q;
	assign rom_rd  = tanh_rom[rd_addr];

	assign t_sum    = U_W'(signed'({1'b0, lo_q})) + U_W'(prod_q >>> 16);
	assign t_rnd    = (t_sum + U_W'(RND_ADD)) >>> RND_SH;
	assign t_val    = neg_q ? -t_rnd : t_rnd;
	assign tanh_res = sat_stage(ACC_W'(t_val));

	assign st_sum = acc_q + ACC_W'(prod_q);
	assign st_sh  = (st_sum + ACC_W'(RND16)) >>> 16;
	assign st_res = sat_stage(st_sh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				y_q[k] <= '0;
			end
		end else if (cmd.acc_op == ACC_STAGE && cmd.commit) begin
			for (int k = 0; k < LAST_STAGE; k++) begin
				y_q[k] <= nxt_q[k];
			end
			y_q[LAST_STAGE] <= st_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= sample_in;
		end
		if (cmd.mul_op != MUL_NONE) begin
			prod_q   <= prod;
			stage_s1 <= cmd.mul_stage;
		end
		case (cmd.tab_rd)
			TAB_LO: lo_q <= rom_rd;
			TAB_HI: hi_q <= rom_rd;
			default: begin
			end
		endcase
		case (cmd.acc_op)
			ACC_FB: begin
				neg_q <= u[U_W-1];
				if (u_big) begin
					idx_q <= TAB_AW'(TANH_DEPTH);
					f_q   <= '0;
				end else begin
					idx_q <= TAB_AW'(pos[FRAC_BITS+2 +: LOG2_DEPTH]);
					f_q   <= pos[FRAC_BITS-14 +: 16];
				end
			end
			ACC_TANH: nxt_q[0] <= tanh_res;
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			ACC_STAGE: begin
				nxt_q[stage_s1] <= st_res;
				if (cmd.capture) begin
					out_q <= sat_sample(st_res);
				end
			end
			default: begin
			end
		endcase
	end

	assign sample_out = out_q;

endmodule

### rtl/nonlinear_ladder_lowpass.sv
// Four-pole resonant ladder lowpass with tanh input stage, two passes per sample.
// A single shared multiplier runs each pass (three multiplies per stage, 18 steps per pass);
// a new sample is accepted only once both passes of the previous one are done.
// Reset clears the ladder state and loads the default cutoff and resonance; no init pass.
// Top level: ties together nll_cfg, nll_ctrl and nll_datapath from nll_pkg.
module nonlinear_ladder_lowpass (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [nll_pkg::SAMPLE_WIDTH-1:0] sample_in,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [nll_pkg::SAMPLE_WIDTH-1:0] sample_out,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [nll_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [nll_pkg::CFG_DATA_W-1:0]          cfg_data
);
	import nll_pkg::*;

	nll_coef_t coef;
	nll_cmd_t  cmd;

	nll_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	nll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	nll_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.cmd        (cmd),
		.coef       (coef),
		.sample_out (sample_out)
	);

endmodule

### dv/testbench.sv
// Self-checking testbench for the nonlinear ladder lowpass (nonlinear_ladder_lowpass).
// Predicts each filtered sample from its own fixed-point ladder model; uses only nll_pkg
// for widths, table depth, stage and pass counts and register indexes.
`timescale 1ns / 100ps

module testbench;

	localparam int SW        = nll_pkg::SAMPLE_WIDTH;
	localparam int STW       = nll_pkg::STAGE_WIDTH;
	localparam int NSTG      = nll_pkg::NUM_STAGES;
	localparam int DEPTH     = nll_pkg::TANH_DEPTH;
	localparam int IDX_W     = nll_pkg::CFG_INDEX_W;
	localparam int DATA_W    = nll_pkg::CFG_DATA_W;
	localparam int CUT_W     = nll_pkg::CUTOFF_W;
	localparam int RES_W     = nll_pkg::RES_W;
	localparam int GAP_MAX   = 19;
	localparam int SETTLE    = 40;
	localparam int CYCLE_CAP = 1000000;
	localparam int CUTOFF_DEFAULT = 6554;
	localparam int UNITY_Q16      = 65536;

	typedef logic signed [SW-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [DATA_W-1:0] CUT_MASK = (DATA_W'(1) << CUT_W) - 1;
	localparam logic [DATA_W-1:0] RES_MASK = (DATA_W'(1) << RES_W) - 1;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	sample_t               sample_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	sample_t               sample_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [DATA_W-1:0]     cfg_data  = '0;

	nonlinear_ladder_lowpass u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// filter model state
	longint                 tanh_lut [DEPTH+1];
	logic signed [STW-1:0]  ladder_q [NSTG];
	logic [CUT_W-1:0]       cutoff_q;
	logic [RES_W-1:0]       resonance_q;

	sample_t     pending_out [$];
	int          mismatch_count = 0;
	int          tx_gap = 0;
	int          tx_gap_max = 0;
	int          rx_stall_max = 0;
	int          rx_hold = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int pick_gap(input int max_gap);
		return (max_gap > 0) ? int'($urandom_range(max_gap, 0)) : 0;
	endfunction

	function automatic longint mul_q31(input longint a, input longint b);
		return (a * b + (longint'(1) <<< 30)) >>> 31;
	endfunction

	// tanh(4k/depth) from an odd series at a sixteenth of the argument, then four doublings
	function automatic longint tanh_point(input int k);
		longint z;
		longint z2;
		longint pw;
		longint t;
		longint den;
		z = ((longint'(k) <<< 31) + 2 * DEPTH) / (4 * DEPTH);
		z2 = mul_q31(z, z);
		pw = mul_q31(z, z2);
		t = z - pw / 3;
		pw = mul_q31(pw, z2);
		t = t + 2 * pw / 15;
		pw = mul_q31(pw, z2);
		t = t - 17 * pw / 315;
		pw = mul_q31(pw, z2);
		t = t + 62 * pw / 2835;
		for (int n = 0; n < 4; n++) begin
			den = (longint'(1) <<< 31) + mul_q31(t, t);
			t = ((t <<< 32) + den / 2) / den;
			if (t > (longint'(1) <<< 31) - 1) begin
				t = (longint'(1) <<< 31) - 1;
			end
		end
		return t;
	endfunction

	function automatic longint clamp(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic longint round16(input longint v);
		return (v + (longint'(1) <<< 15)) >>> 16;
	endfunction

	// table tanh with linear interpolation, odd symmetry, rounded to the sample fraction
	function automatic longint tanh_interp(input longint u);
		longint mag;
		longint pos;
		longint idx;
		longint frac;
		longint t;
		longint res;
		mag = (u < 0) ? -u : u;
		pos = mag * DEPTH;
		idx = pos >>> (nll_pkg::FRAC_BITS + 2);
		if (idx >= DEPTH) begin
			t = tanh_lut[DEPTH];
		end else begin
			frac = (pos >>> (nll_pkg::FRAC_BITS + 2 - 16)) % 65536;
			t = tanh_lut[idx] + (((tanh_lut[idx+1] - tanh_lut[idx]) * frac) >>> 16);
		end
		res = (t + (longint'(1) <<< (30 - nll_pkg::FRAC_BITS))) >>> (31 - nll_pkg::FRAC_BITS);
		return (u < 0) ? -res : res;
	endfunction

	// two ladder passes per sample: the sample on the first, zero on the second
	function automatic sample_t ladder_predict(input sample_t x_in);
		longint g;
		longint h0;
		longint h1;
		longint c;
		longint r;
		longint x;
		longint d;
		longint u;
		longint acc;
		longint first;
		longint nxt [NSTG];
		int p;
		int i;
		g = longint'(cutoff_q);
		h0 = (g * 10 + 6) / 13;
		h1 = (g * 3 + 6) / 13;
		c = UNITY_Q16 - g;
		r = longint'(resonance_q);
		first = 0;
		for (p = 0; p < nll_pkg::OVERSAMPLE; p++) begin
			x = (p == 0) ? longint'(x_in) : 0;
			d = 2 * longint'(ladder_q[NSTG-1]) - x;
			u = x - round16(2 * r * d);
			nxt[0] = clamp(tanh_interp(u), STW);
			for (i = 1; i < NSTG; i++) begin
				acc = h0 * nxt[i-1] + h1 * longint'(ladder_q[i-1]) + c * longint'(ladder_q[i]);
				nxt[i] = clamp(round16(acc), STW);
			end
			for (i = 0; i < NSTG; i++) begin
				ladder_q[i] = STW'(nxt[i]);
			end
			if (p == 0) begin
				first = nxt[NSTG-1];
			end
		end
		return sample_t'(clamp(first, SW));
	endfunction

	task automatic send_sample(input sample_t v);
		if (tx_gap > 0) begin
			repeat (tx_gap) @(posedge clk);
		end
		if (in_valid !== 1'b1) begin
			in_valid <= 1'b1;
		end
		sample_in <= v;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_out.push_back(ladder_predict(v));
		// keep valid up only when the next transaction follows right away
		tx_gap = pick_gap(tx_gap_max);
		if (tx_gap > 0) begin
			in_valid <= 1'b0;
		end
	endtask

	task automatic settle();
		if (tx_gap == 0 && in_valid === 1'b1) begin
			in_valid <= 1'b0;
		end
		@(posedge clk);
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == nll_pkg::CFG_CUTOFF) begin
			cutoff_q = data[CUT_W-1:0];
		end else if (idx == nll_pkg::CFG_RESONANCE) begin
			resonance_q = data[RES_W-1:0];
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_filter(input int unsigned cut, input int unsigned res);
		logic [DATA_W-1:0] junk;
		junk = $urandom_range(1, 0) ? DATA_W'($urandom()) : '0;
		write_reg(nll_pkg::CFG_CUTOFF, (junk & ~CUT_MASK) | (DATA_W'(cut) & CUT_MASK));
		junk = $urandom_range(1, 0) ? DATA_W'($urandom()) : '0;
		write_reg(nll_pkg::CFG_RESONANCE, (junk & ~RES_MASK) | (DATA_W'(res) & RES_MASK));
	endtask

	task automatic write_unknown_reg();
		int max_idx;
		max_idx = (1 << IDX_W) - 1;
		write_reg(IDX_W'($urandom_range(max_idx, int'(nll_pkg::CFG_RESONANCE) + 1)),
			DATA_W'($urandom()));
	endtask

	// result side: per-result stall while out_valid is up, plus an optional long hold
	initial begin
		int stall;
		sample_t want;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (pending_out.size() == 0) begin
					$error("sample_out: no transaction expected, actual %0d", sample_out);
					mismatch_count++;
				end else begin
					want = pending_out.pop_front();
					if (sample_out !== want) begin
						$error("sample_out: expected %0d, actual %0d", want, sample_out);
						mismatch_count++;
					end
				end
				stall = pick_gap(rx_stall_max);
			end else if (out_valid === 1'b1 && stall > 0) begin
				stall--;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (stall == 0);
			end
		end
	end

	task automatic test_default_settings();
		sample_t seq [10];
		seq = '{sample_t'(0), SAMPLE_MAX, SAMPLE_MIN, sample_t'(-1), sample_t'(1),
			SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, sample_t'(0)};
		tx_gap_max = GAP_MAX;
		rx_stall_max = GAP_MAX;
		foreach (seq[k]) send_sample(seq[k]);
		settle();
	endtask

	// full resonance with a wide cutoff drives the tanh argument past the table end
	task automatic test_large_argument();
		set_filter(2 * UNITY_Q16, UNITY_Q16);
		for (int k = 0; k < 6; k++) begin
			send_sample((k % 2) ? SAMPLE_MIN : SAMPLE_MAX);
		end
		settle();
	endtask

	// register values past their range, negative (1-g), stages run into saturation
	task automatic test_overrange_registers();
		set_filter(CUT_MASK, RES_MASK);
		for (int k = 0; k < 4; k++) begin
			send_sample((k % 2) ? SAMPLE_MIN : SAMPLE_MAX);
		end
		send_sample(sample_t'(0));
		settle();
		set_filter(0, 0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		settle();
	endtask

	task automatic test_unknown_index();
		write_reg({IDX_W{1'b1}}, {DATA_W{1'b1}});
		write_unknown_reg();
		write_unknown_reg();
		send_sample(SAMPLE_MAX);
		send_sample(sample_t'(-1));
		settle();
	endtask

	task automatic test_random_settings();
		int unsigned cut;
		int unsigned res;
		int amp;
		int pick;
		sample_t v;
		for (int ph = 0; ph < 13; ph++) begin
			case ($urandom_range(9, 0))
				0: cut = 0;
				1: cut = 2 * UNITY_Q16;
				2: cut = CUT_MASK;
				3: cut = $urandom_range(CUT_MASK, 0);
				default: cut = $urandom_range(40000, 0);
			endcase
			case ($urandom_range(7, 0))
				0: res = 0;
				1: res = UNITY_Q16;
				2: res = RES_MASK;
				default: res = $urandom_range(UNITY_Q16, 0);
			endcase
			if ($urandom_range(3, 0) == 0) begin
				write_unknown_reg();
			end
			set_filter(cut, res);
			case (ph % 4)
				0: begin tx_gap_max = GAP_MAX; rx_stall_max = GAP_MAX; end
				1: begin tx_gap_max = 0;       rx_stall_max = 0;       end
				2: begin tx_gap_max = GAP_MAX; rx_stall_max = 0;       end
				default: begin tx_gap_max = 0; rx_stall_max = GAP_MAX; end
			endcase
			amp = $urandom_range(int'(SAMPLE_MAX), 0);
			for (int k = 0; k < 120; k++) begin
				pick = $urandom_range(9, 0);
				if (pick < 5) begin
					v = sample_t'($urandom());
				end else if (pick < 7) begin
					v = sample_t'(int'($urandom_range(4095, 0)) - 2048);
				end else if (pick == 7) begin
					case ($urandom_range(3, 0))
						0: v = SAMPLE_MAX;
						1: v = SAMPLE_MIN;
						2: v = sample_t'(0);
						default: v = sample_t'(-1);
					endcase
				end else begin
					// square wave, rings the ladder at high resonance
					v = ((k / 8) % 2) ? sample_t'(-amp) : sample_t'(amp);
				end
				send_sample(v);
			end
			settle();
		end
	endtask

	// receiver holds off long enough that the block backs up onto its input
	task automatic test_output_backpressure();
		set_filter($urandom_range(40000, 1000), $urandom_range(UNITY_Q16, 0));
		tx_gap_max = 0;
		rx_stall_max = 0;
		rx_hold = 900;
		for (int k = 0; k < 60; k++) begin
			send_sample(sample_t'($urandom()));
		end
		settle();
	endtask

	initial begin
		for (int k = 0; k <= DEPTH; k++) begin
			tanh_lut[k] = tanh_point(k);
		end
		for (int k = 0; k < NSTG; k++) begin
			ladder_q[k] = '0;
		end
		cutoff_q = CUT_W'(CUTOFF_DEFAULT);
		resonance_q = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_large_argument();
		test_overrange_registers();
		test_unknown_index();
		test_random_settings();
		test_output_backpressure();

		if (mismatch_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
